[hw/rtl/sdpc_pkg.sv]
// ----------------------------------------------------------------------------
// Sonar direction person counter package
// Shared widths, packed layouts and per-cell flag types.
// ----------------------------------------------------------------------------
package sdpc_pkg;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned THRESHOLD_W = 3;

   // Reset value of the presence threshold register.
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 3'd2;

   // Payload widths on the stream channels, padded to whole bytes.
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_BITS   = 3 + 3 * COUNT_W + 1;
   localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // What one cell reports about the triple that starts at its own sample.
   typedef struct packed {
      logic nonzero;
      logic rise;
      logic fall;
   } cell_flags_type;

   // One result item as it leaves the tally logic.
   typedef struct packed {
      logic               latched;
      logic [COUNT_W-1:0] total_count;
      logic [COUNT_W-1:0] away_count;
      logic [COUNT_W-1:0] towards_count;
      logic               moving_away;
      logic               moving_towards;
      logic               present;
   } tally_type;

endpackage

[hw/rtl/sdpc_cell.sv]
// ----------------------------------------------------------------------------
// Sample cell
// Holds one sonar sample of the window, passes it to the next older cell on
// every transfer and classifies the triple formed with its two newer neighbors.
// ----------------------------------------------------------------------------
module sdpc_cell
   import sdpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic [SAMPLE_W-1:0] sample_in,
   input  logic [SAMPLE_W-1:0] newer_near,
   input  logic [SAMPLE_W-1:0] newer_far,
   output logic [SAMPLE_W-1:0] sample_out,
   output cell_flags_type      flags_out
);

   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] sample_in_next;

   // Take the neighbor's sample on each accepted transfer.
   assign sample_in_next = shift_en ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_next;
      end
   end

   assign sample_out = sample_ff;

   // This cell is the oldest sample of its triple; the far neighbor is newest.
   always_comb begin
      flags_out.nonzero = (sample_ff != '0);
      flags_out.rise    = (sample_ff < newer_near) && (newer_near < newer_far) &&
                          (sample_ff != '0);
      flags_out.fall    = (sample_ff > newer_near) && (newer_near > newer_far) &&
                          (newer_far != '0);
   end

endmodule

[hw/rtl/sdpc_tally.sv]
// ----------------------------------------------------------------------------
// Person tally
// Decides presence and direction from the cell flags and keeps the
// per-direction counters and the counted-once latch.
// ----------------------------------------------------------------------------
module sdpc_tally
   import sdpc_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  logic [THRESHOLD_W-1:0] threshold,
   input  cell_flags_type         cell_flags [WINDOW_DEPTH],
   output tally_type              tally
);

   localparam int unsigned POP_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned CMP_W = POP_W + THRESHOLD_W;

   logic [COUNT_W-1:0] towards_ff, towards_in;
   logic [COUNT_W-1:0] away_ff, away_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               latch_ff, latch_in;
   logic [POP_W-1:0]   nonzero_cnt;
   logic               present;
   logic               towards;
   logic               away;
   logic               count_now;

   // Gather the per-cell flags.
   always_comb begin
      nonzero_cnt = '0;
      towards     = 1'b0;
      away        = 1'b0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         nonzero_cnt = nonzero_cnt + POP_W'(cell_flags[i].nonzero);
         towards     = towards | cell_flags[i].fall;
         away        = away | cell_flags[i].rise;
      end
   end

   assign present   = CMP_W'(nonzero_cnt) > CMP_W'(threshold);
   assign count_now = !latch_ff && present && (towards || away);

   // Next counter and latch values; towards wins when both directions show.
   always_comb begin
      towards_in = towards_ff;
      away_in    = away_ff;
      total_in   = total_ff;
      if (count_now) begin
         total_in = total_ff + COUNT_W'(1);
         if (towards) begin
            towards_in = towards_ff + COUNT_W'(1);
         end else begin
            away_in = away_ff + COUNT_W'(1);
         end
      end
      latch_in = present && (latch_ff || towards || away);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         towards_ff <= '0;
         away_ff    <= '0;
         total_ff   <= '0;
         latch_ff   <= 1'b0;
      end else if (update) begin
         towards_ff <= towards_in;
         away_ff    <= away_in;
         total_ff   <= total_in;
         latch_ff   <= latch_in;
      end
   end

   // The result carries the values after this sample's update.
   always_comb begin
      tally.present        = present;
      tally.moving_towards = towards;
      tally.moving_away    = away;
      tally.towards_count  = towards_in;
      tally.away_count     = away_in;
      tally.total_count    = total_in;
      tally.latched        = latch_in;
   end

   // The total moves in step with exactly one of the direction counters.
   assert property (@(posedge clock) disable iff (reset)
      update && count_now |=> (total_ff == COUNT_W'($past(total_ff) + COUNT_W'(1))) &&
         ((towards_ff != $past(towards_ff)) != (away_ff != $past(away_ff))))
      else $error("tally: total and direction counters out of step");

   // Nothing changes between samples.
   assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(total_ff) && $stable(towards_ff) && $stable(away_ff) &&
         $stable(latch_ff))
      else $error("tally: state changed without a sample");

   // The counted-once latch clears on a sample with nobody present.
   assert property (@(posedge clock) disable iff (reset)
      latch_ff && update && !present |=> !latch_ff)
      else $error("tally: latch held with nobody present");

endmodule

[hw/rtl/sonar_direction_person_counter.sv]
// ----------------------------------------------------------------------------
// Sonar direction person counter
// Counts people passing a sonar, by direction, from a stream of distances.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the req_ channel carries one sonar distance (zero means
//   no echo). Each accepted distance yields exactly one transfer on the rsp_
//   channel with the presence and direction flags and the running counts.
//   The csr_ channel writes the presence threshold; csr_ready is always high.
//   Writes are to be made while no sample is in flight; the block does not enforce it.
//   An accepted sample is registered in the cells and its result then in rsp_tdata.
//   Throughput: one sample per cycle while the receiver takes results, set by the
//   row of sample cells that shifts once per transfer and the single tally stage after it.
//   When the receiver stalls, the finished result waits in the output
//   register while one further sample is taken into the cells; after that
//   req_tready drops until the output is taken.
//   Reset clears the sample window, the counters, the latch and both
//   valid flags, and sets the threshold to two.
// ----------------------------------------------------------------------------
module sonar_direction_person_counter
   import sdpc_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [15:0] distance
   // Result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] present, [1] moving_towards, [2] moving_away, [18:3] towards_count,
   // [34:19] away_count, [50:35] total_count, [51] latched, rest zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Threshold write port
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [THRESHOLD_W-1:0] csr_data     // presence_threshold
);

   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                   req_xfer;
   logic                   advance;
   logic                   load;
   logic [SAMPLE_W-1:0]    samples [WINDOW_DEPTH];
   cell_flags_type         flags [WINDOW_DEPTH];
   tally_type              tally;

   // Threshold register.
   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // Handshake: a sample sits in the cells until its result can be loaded.
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign load       = pend_ff && advance;
   assign req_tready = !pend_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      pend_in = pend_ff;
      if (req_xfer) begin
         pend_in = 1'b1;
      end else if (load) begin
         pend_in = 1'b0;
      end
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      rsp_tdata_in = load ? RSP_DATA_W'(tally) : rsp_tdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Row of cells: cell 0 holds the newest sample, the last cell the oldest.
   // Each cell sees its two newer neighbors, wrapping around the window.
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      localparam int unsigned NEAR = (i + WINDOW_DEPTH - 1) % WINDOW_DEPTH;
      localparam int unsigned FAR  = (i + WINDOW_DEPTH - 2) % WINDOW_DEPTH;
      logic [SAMPLE_W-1:0] feed;

      if (i == 0) begin : g_head
         assign feed = req_tdata[SAMPLE_W-1:0];
      end else begin : g_body
         assign feed = samples[i-1];
      end

      sdpc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (req_xfer),
         .sample_in  (feed),
         .newer_near (samples[NEAR]),
         .newer_far  (samples[FAR]),
         .sample_out (samples[i]),
         .flags_out  (flags[i])
      );
   end

   // Presence, direction and counting.
   sdpc_tally #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_tally (
      .clock      (clock),
      .reset      (reset),
      .update     (load),
      .threshold  (threshold_ff),
      .cell_flags (flags),
      .tally      (tally)
   );

   // An accepted sample is always waiting in the cells on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> pend_ff)
      else $error("top: accepted sample lost before its result");

   // A stalled result with a sample behind it blocks further input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && pend_ff |-> !req_tready)
      else $error("top: input taken while the pipeline is full");

   // A result is loaded only for a waiting sample.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pend_ff))
      else $error("top: result produced without a sample");

endmodule
